>>> rtl/sml_pkg.sv
`timescale 1ns / 1ps
// sml_pkg: shared types and constants of the sync marker length deframer
// no dependencies; used by the interfaces, the window cell, control and top

package sml_pkg;

  localparam int unsigned MarkerLen = 27;
  // window cells kept between items: marker plus three header words, minus
  // the byte that arrives with the current item
  localparam int unsigned WinCells = MarkerLen + 12 - 1;
  localparam int unsigned WordW = 31;
  localparam logic [WordW-1:0] LimitReset = 31'd10000000;

  // sync marker: 26 ascii characters and a terminating zero byte
  localparam logic [7:0] SyncMarker [MarkerLen] = '{
    8'h5B, 8'h6F, 8'h66, 8'h78, 8'h4B, 8'h75, 8'h4E, 8'h65, 8'h74,
    8'h77, 8'h6F, 8'h72, 8'h6B, 8'h20, 8'h64, 8'h61, 8'h74, 8'h61,
    8'h20, 8'h70, 8'h61, 8'h63, 8'h6B, 8'h65, 8'h74, 8'h5D, 8'h00
  };

  // what a window cell compares its byte with
  typedef struct packed {
    logic       care;
    logic [7:0] value;
  } cell_ref_t;

  // control from the frame logic to the window chain
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // header candidate seen in the window after the current byte
  typedef struct packed {
    logic        hit;
    logic [31:0] frame;
    logic [31:0] size;
    logic [31:0] source;
  } hdr_t;

  // one result item
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [WordW-1:0] frame_number;
    logic [WordW-1:0] source_word;
    logic [WordW-1:0] byte_offset;
    logic             last_byte;
    logic             empty_frame;
  } res_t;

  function automatic cell_ref_t cell_ref(int unsigned k);
    cell_ref_t r;
    logic [4:0] idx;
    idx = 5'(k);
    r.care = 1'b0;
    r.value = 8'h00;
    if (k < MarkerLen) begin
      r.care = 1'b1;
      r.value = SyncMarker[idx];
    end
    return r;
  endfunction

endpackage

>>> rtl/sml_if.sv
`timescale 1ns / 1ps
// sml_in_if / sml_out_if: valid-ready channels of the deframer
// depends on sml_pkg for the field width

interface sml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_reset;

  modport source (output valid, rx_byte, link_reset, input ready);
  modport sink (input valid, rx_byte, link_reset, output ready);
endinterface

interface sml_out_if;
  logic                            valid;
  logic                            ready;
  logic [7:0]                      payload_byte;
  logic [sml_pkg::WordW-1:0]       frame_number;
  logic [sml_pkg::WordW-1:0]       source_word;
  logic [sml_pkg::WordW-1:0]       byte_offset;
  logic                            last_byte;
  logic                            empty_frame;

  modport source (output valid, payload_byte, frame_number, source_word, byte_offset,
                  last_byte, empty_frame, input ready);
  modport sink (input valid, payload_byte, frame_number, source_word, byte_offset,
                last_byte, empty_frame, output ready);
endinterface

>>> rtl/sml_win_cell.sv
`timescale 1ns / 1ps
// sml_win_cell: one byte of the header search window
// depends on sml_pkg (win_ctl_t, cell_ref_t)

module sml_win_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sml_pkg::win_ctl_t   ctl_i,
  input  sml_pkg::cell_ref_t  ref_i,
  input  logic [7:0]          byte_i,
  output logic [7:0]          byte_o,
  output logic                hit_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = !ref_i.care || (byte_q == ref_i.value);

endmodule

>>> rtl/sml_ctrl.sv
`timescale 1ns / 1ps
// sml_ctrl: header check, payload counting and the result register
// depends on sml_pkg (hdr_t, win_ctl_t, res_t)

module sml_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_acc_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          link_reset_i,
  input  sml_pkg::hdr_t                 hdr_i,
  input  logic [sml_pkg::WordW-1:0]     limit_i,
  input  logic                          out_ready_i,
  output logic                          in_ready_o,
  output sml_pkg::win_ctl_t             win_o,
  output logic                          out_valid_o,
  output sml_pkg::res_t                 res_o
);

  localparam int unsigned W = sml_pkg::WordW;

  logic         in_payload_q, in_payload_d;
  logic [W-1:0] remain_q, remain_d;
  logic [W-1:0] frame_q, frame_d;
  logic [W-1:0] source_q, source_d;
  logic [W-1:0] offset_q, offset_d;
  logic         out_valid_q, out_valid_d;
  sml_pkg::res_t res_q, res_d;

  logic hdr_ok, take, fire, last;

  always_comb begin
    hdr_ok = hdr_i.hit && !hdr_i.frame[31] && !hdr_i.size[31] && !hdr_i.source[31]
             && (hdr_i.size[W-1:0] < limit_i);
    take = in_acc_i && !link_reset_i;
    last = (remain_q <= W'(1));

    win_o.clear = in_acc_i && (link_reset_i || (!in_payload_q && hdr_ok));
    win_o.shift = take && !in_payload_q;

    in_payload_d = in_payload_q;
    remain_d     = remain_q;
    frame_d      = frame_q;
    source_d     = source_q;
    offset_d     = offset_q;
    fire         = 1'b0;
    res_d        = res_q;

    if (in_acc_i && link_reset_i) begin
      in_payload_d = 1'b0;
      remain_d     = '0;
      frame_d      = '0;
      source_d     = '0;
      offset_d     = '0;
    end else if (take && in_payload_q) begin
      // payload byte
      fire               = 1'b1;
      res_d.payload_byte = rx_byte_i;
      res_d.frame_number = frame_q;
      res_d.source_word  = source_q;
      res_d.byte_offset  = offset_q;
      res_d.last_byte    = last;
      res_d.empty_frame  = 1'b0;
      offset_d           = offset_q + W'(1);
      if (last) begin
        in_payload_d = 1'b0;
        remain_d     = '0;
      end else begin
        remain_d = remain_q - W'(1);
      end
    end else if (take && hdr_ok) begin
      frame_d  = hdr_i.frame[W-1:0];
      source_d = hdr_i.source[W-1:0];
      offset_d = '0;
      if (hdr_i.size[W-1:0] == '0) begin
        // empty frame gives its single result at once
        fire               = 1'b1;
        res_d.payload_byte = 8'h00;
        res_d.frame_number = hdr_i.frame[W-1:0];
        res_d.source_word  = hdr_i.source[W-1:0];
        res_d.byte_offset  = '0;
        res_d.last_byte    = 1'b1;
        res_d.empty_frame  = 1'b1;
      end else begin
        in_payload_d = 1'b1;
        remain_d     = hdr_i.size[W-1:0];
      end
    end

    out_valid_d = fire || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      remain_q     <= '0;
      frame_q      <= '0;
      source_q     <= '0;
      offset_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      in_payload_q <= in_payload_d;
      remain_q     <= remain_d;
      frame_q      <= frame_d;
      source_q     <= source_d;
      offset_q     <= offset_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/sync_marker_length_deframer_top.sv
`timescale 1ns / 1ps
// sync_marker_length_deframer_top: top level of the byte stream deframer
// depends on sml_pkg, sml_if, sml_win_cell and sml_ctrl

// The deframer takes one received byte per item and hunts for a 27-byte
// sync marker followed by three little-endian signed 32-bit words: frame
// number, payload size and source. A header counts when all three words are
// non-negative and the size is strictly below max_payload_limit (written
// through cfg_we_i / cfg_wdata_i, reset 10000000; write only while idle).
// The next size bytes come out one result each, tagged with frame, source,
// offset and a last mark; a zero size gives one empty-frame result on the
// byte that completes the header. Header bytes are consumed, and hunting
// restarts after each payload. link_reset on an item drops any partial
// header or payload; its byte is discarded. Rate: one item per cycle while
// the output register is free; each result appears the cycle after its
// byte. The search window is a chain of 38 byte cells shifting once per
// hunted byte; the marker compare and header checks run in parallel across
// the cells in the same cycle. A single output register decouples the
// sides: input is ready whenever that register is empty or being taken.

module sync_marker_length_deframer_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sml_in_if.sink                      in_i,
  sml_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [sml_pkg::WordW-1:0]   cfg_wdata_i
);

  localparam int unsigned N  = sml_pkg::WinCells;
  localparam int unsigned ML = sml_pkg::MarkerLen;

  // payload size limit register
  logic [sml_pkg::WordW-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sml_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // window chain: cell 0 is the oldest byte kept, cell N-1 the newest
  sml_pkg::win_ctl_t win_ctl;
  logic [7:0]        win_byte [N];
  logic [N-1:0]      win_hit;
  logic              in_acc;

  assign in_acc = in_i.valid && in_i.ready;

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam sml_pkg::cell_ref_t CellRef = sml_pkg::cell_ref(k);
    logic [7:0] next_byte;

    // each cell loads its younger neighbor; the last one loads the new byte
    if (k == N - 1) begin : g_tail
      assign next_byte = in_i.rx_byte;
    end else begin : g_body
      assign next_byte = win_byte[k+1];
    end

    sml_win_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (win_ctl),
      .ref_i  (CellRef),
      .byte_i (next_byte),
      .byte_o (win_byte[k]),
      .hit_o  (win_hit[k])
    );
  end

  // header as it stands once the incoming byte is shifted in:
  // marker in cells 0..26, words behind it, top source byte is the new byte
  sml_pkg::hdr_t hdr;

  always_comb begin
    hdr.hit    = &win_hit;
    hdr.frame  = {win_byte[ML+3], win_byte[ML+2], win_byte[ML+1], win_byte[ML]};
    hdr.size   = {win_byte[ML+7], win_byte[ML+6], win_byte[ML+5], win_byte[ML+4]};
    hdr.source = {in_i.rx_byte, win_byte[ML+10], win_byte[ML+9], win_byte[ML+8]};
  end

  sml_pkg::res_t res;
  logic          in_ready;
  logic          out_valid;

  sml_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_acc_i     (in_acc),
    .rx_byte_i    (in_i.rx_byte),
    .link_reset_i (in_i.link_reset),
    .hdr_i        (hdr),
    .limit_i      (limit_q),
    .out_ready_i  (out_o.ready),
    .in_ready_o   (in_ready),
    .win_o        (win_ctl),
    .out_valid_o  (out_valid),
    .res_o        (res)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid;
  assign out_o.payload_byte = res.payload_byte;
  assign out_o.frame_number = res.frame_number;
  assign out_o.source_word  = res.source_word;
  assign out_o.byte_offset  = res.byte_offset;
  assign out_o.last_byte    = res.last_byte;
  assign out_o.empty_frame  = res.empty_frame;

endmodule

>>> dv/tb_sync_marker_length_deframer_top.sv
`timescale 1ns / 1ps
// tb_sync_marker_length_deframer_top: self-checking bench for the byte stream deframer
// depends on sml_pkg, sml_if and the rtl below sync_marker_length_deframer_top

module tb_sync_marker_length_deframer_top;

  // header is the marker plus frame, size and source words
  localparam int HdrLen = sml_pkg::MarkerLen + 12;

  // kinds of rows in the directed table
  typedef enum logic [2:0] {
    ROW_NOISE,       // size field holds the number of random bytes
    ROW_PREFIX,      // size field holds how many leading marker bytes to send
    ROW_FRAME,       // full header, then payload
    ROW_LINK_RESET,  // a lone link reset item
    ROW_LIMIT        // drain, then write max_payload_limit from the size field
  } row_kind_e;

  // how payload bytes are filled in
  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_NESTED,   // payload opens with a complete valid header
    FILL_EXTREME   // alternating 0x00 / 0xff
  } fill_e;

  typedef struct {
    row_kind_e     kind;
    logic [31:0]   frame;
    logic [31:0]   size;
    logic [31:0]   source;
    int            cut;    // link reset after this many bytes, -1 for none
    int            flip;   // header byte to corrupt, -1 for none
    fill_e         fill;
    bit            typed;  // empty-frame result typed in below
    sml_pkg::res_t exp;
  } row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [sml_pkg::WordW-1:0] cfg_wdata;

  sml_in_if  in_if ();
  sml_out_if out_if ();

  sync_marker_length_deframer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: shift window, payload tracking and the size limit
  // ---------------------------------------------------------------------------
  logic [7:0]                win_q [HdrLen];
  logic                      pay_active;
  logic [sml_pkg::WordW-1:0] pay_left;
  logic [sml_pkg::WordW-1:0] cur_frame;
  logic [sml_pkg::WordW-1:0] cur_source;
  logic [sml_pkg::WordW-1:0] cur_offset;
  logic [sml_pkg::WordW-1:0] size_limit;

  sml_pkg::res_t frame_results_q [$];  // results still owed by the block, oldest first
  int            err_count;
  int            items_sent;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_cycles;          // long receiver hold-off, counted down by the receiver
  sml_pkg::res_t seen;
  sml_pkg::res_t want;
  row_t          dir_rows [27];

  function automatic void clear_deframer();
    foreach (win_q[i]) win_q[i] = 8'h00;
    pay_active = 1'b0;
    pay_left   = '0;
    cur_frame  = '0;
    cur_source = '0;
    cur_offset = '0;
  endfunction

  // one accepted input item; returns 1 when the block owes a result for it
  function automatic bit deframe_step(input logic [7:0] b, input logic lr,
                                      output sml_pkg::res_t r);
    logic [31:0] w_frame;
    logic [31:0] w_size;
    logic [31:0] w_source;
    bit          hit;
    r = '0;
    // link reset wipes everything but the limit, and its byte is dropped
    if (lr) begin
      clear_deframer();
      return 1'b0;
    end
    // payload bytes pass straight through and are never hunted
    if (pay_active) begin
      r.payload_byte = b;
      r.frame_number = cur_frame;
      r.source_word  = cur_source;
      r.byte_offset  = cur_offset;
      r.last_byte    = (pay_left <= 1);
      cur_offset     = cur_offset + 1'b1;
      if (r.last_byte) begin
        pay_active = 1'b0;
        pay_left   = '0;
      end else begin
        pay_left = pay_left - 1'b1;
      end
      return 1'b1;
    end
    for (int i = 0; i < HdrLen - 1; i++) win_q[i] = win_q[i+1];
    win_q[HdrLen-1] = b;
    hit = 1'b1;
    for (int i = 0; i < sml_pkg::MarkerLen; i++) begin
      if (win_q[i] != sml_pkg::SyncMarker[i]) hit = 1'b0;
    end
    for (int k = 0; k < 4; k++) begin
      w_frame[8*k +: 8]  = win_q[sml_pkg::MarkerLen + k];
      w_size[8*k +: 8]   = win_q[sml_pkg::MarkerLen + 4 + k];
      w_source[8*k +: 8] = win_q[sml_pkg::MarkerLen + 8 + k];
    end
    // negative words or an oversize length: keep hunting with the window as is
    if (!hit || w_frame[31] || w_size[31] || w_source[31]) return 1'b0;
    if (w_size >= {1'b0, size_limit}) return 1'b0;
    // header consumed
    foreach (win_q[i]) win_q[i] = 8'h00;
    cur_frame  = w_frame[sml_pkg::WordW-1:0];
    cur_source = w_source[sml_pkg::WordW-1:0];
    cur_offset = '0;
    if (w_size == 0) begin
      r.frame_number = cur_frame;
      r.source_word  = cur_source;
      r.last_byte    = 1'b1;
      r.empty_frame  = 1'b1;
      return 1'b1;
    end
    pay_active = 1'b1;
    pay_left   = w_size[sml_pkg::WordW-1:0];
    return 1'b0;
  endfunction

  function automatic sml_pkg::res_t empty_res(input logic [sml_pkg::WordW-1:0] fr, src);
    sml_pkg::res_t r;
    r = '0;
    r.frame_number = fr;
    r.source_word  = src;
    r.last_byte    = 1'b1;
    r.empty_frame  = 1'b1;
    return r;
  endfunction

  function automatic void build_header(output logic [7:0] h [HdrLen],
                                       input logic [31:0] fr, sz, src);
    for (int i = 0; i < sml_pkg::MarkerLen; i++) h[i] = sml_pkg::SyncMarker[i];
    for (int k = 0; k < 4; k++) begin
      h[sml_pkg::MarkerLen + k]     = fr[8*k +: 8];
      h[sml_pkg::MarkerLen + 4 + k] = sz[8*k +: 8];
      h[sml_pkg::MarkerLen + 8 + k] = src[8*k +: 8];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one byte item per call, with random idle cycles before it;
  // inputs move on the falling edge, the handshake is seen on the rising one
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b, input logic lr,
                          input bit use_typed = 1'b0, input sml_pkg::res_t typed = '0);
    sml_pkg::res_t r;
    bit            owed;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.rx_byte    <= b;
    in_if.link_reset <= lr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    owed = deframe_step(b, lr, r);
    // a typed-in result replaces the predicted one on that item
    if (use_typed) frame_results_q.push_back(typed);
    else if (owed) frame_results_q.push_back(r);
    items_sent++;
  endtask

  // header (optionally corrupted), payload, optional link reset part way through
  task automatic send_frame(input logic [31:0] fr, sz, src, input int cut, input int flip,
                            input fill_e fill, input bit typed, input sml_pkg::res_t exp);
    logic [7:0] hdr [HdrLen];
    logic [7:0] nest [HdrLen];
    logic [7:0] b;
    int         n_pay;
    int         total;
    build_header(hdr, fr, sz, src);
    if (flip >= 0) hdr[flip] ^= 8'h01;
    build_header(nest, 32'd1, 32'd0, 32'd1);
    // huge sizes only get a few bytes; a cut or a later link reset ends them
    n_pay = (sz <= 200) ? int'(sz) : 8;
    total = HdrLen + n_pay;
    if (cut >= 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < HdrLen) begin
        b = hdr[i];
      end else begin
        case (fill)
          FILL_NESTED:  b = (i - HdrLen < HdrLen) ? nest[i - HdrLen] : 8'($urandom);
          FILL_EXTREME: b = (i % 2 != 0) ? 8'hFF : 8'h00;
          default:      b = 8'($urandom);
        endcase
      end
      put_byte(b, 1'b0, typed && (i == HdrLen - 1), exp);
    end
    if (cut >= 0) put_byte(8'($urandom), 1'b1);
  endtask

  // stop offering, then wait until every owed result has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    // margin for the registered result and for a header item still in flight
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [sml_pkg::WordW-1:0] v);
    wait_drained();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    size_limit = v;
  endtask

  // random traffic: mostly well-formed frames, mixed with broken headers, cut
  // frames, noise with stray link resets, and dangling marker prefixes
  task automatic run_random(input int n_items);
    int          stop_at;
    int          pick;
    int          sz_cap;
    int          k;
    logic [31:0] fr;
    logic [31:0] sz;
    logic [31:0] src;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      fr   = $urandom & 32'h7FFF_FFFF;
      src  = $urandom & 32'h7FFF_FFFF;
      if ($urandom_range(7) == 0) fr = 32'h7FFF_FFFF;
      if ($urandom_range(7) == 0) src = 32'h0;
      // keep sizes small and mostly legal under the current limit
      sz_cap = (size_limit == 0) ? 0 : ((size_limit > 16) ? 16 : int'(size_limit) - 1);
      sz = 32'($urandom_range(sz_cap));
      if (size_limit > 40 && $urandom_range(19) == 0) sz = 32'($urandom_range(40));
      if (pick < 60) begin
        send_frame(fr, sz, src, -1, -1, FILL_RANDOM, 1'b0, '0);
      end else if (pick < 70) begin
        case ($urandom_range(4))
          0: send_frame(fr, sz, src, -1, $urandom_range(sml_pkg::MarkerLen - 1), FILL_RANDOM,
                        1'b0, '0);
          1: send_frame(fr | 32'h8000_0000, sz, src, -1, -1, FILL_RANDOM, 1'b0, '0);
          2: send_frame(fr, sz | 32'h8000_0000, src, -1, -1, FILL_RANDOM, 1'b0, '0);
          3: send_frame(fr, sz, src | 32'h8000_0000, -1, -1, FILL_RANDOM, 1'b0, '0);
          default: send_frame(fr, {1'b0, size_limit}, src, -1, -1, FILL_RANDOM, 1'b0, '0);
        endcase
      end else if (pick < 80) begin
        send_frame(fr, sz, src, $urandom_range(HdrLen - 1 + int'(sz)), -1, FILL_RANDOM,
                   1'b0, '0);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom), ($urandom_range(15) == 0));
      end else begin
        k = $urandom_range(1, sml_pkg::MarkerLen - 1);
        for (int j = 0; j < k; j++) put_byte(sml_pkg::SyncMarker[j], 1'b0);
        put_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a long hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every taken result against the oldest owed one
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen = '{out_if.payload_byte, out_if.frame_number, out_if.source_word,
               out_if.byte_offset, out_if.last_byte, out_if.empty_frame};
      if (frame_results_q.size() == 0) begin
        $display("%0t: result item with none owed, expected nothing, got %h", $time, seen);
        err_count++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("payload_byte", want.payload_byte, seen.payload_byte);
        check_field("frame_number", want.frame_number, seen.frame_number);
        check_field("source_word", want.source_word, seen.source_word);
        check_field("byte_offset", want.byte_offset, seen.byte_offset);
        check_field("last_byte", want.last_byte, seen.last_byte);
        check_field("empty_frame", want.empty_frame, seen.empty_frame);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid      = 1'b0;
    in_if.rx_byte    = 8'h00;
    in_if.link_reset = 1'b0;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cycles      = 0;
    err_count        = 0;
    items_sent       = 0;
    rst_ni           = 1'b0;
    clear_deframer();
    size_limit = sml_pkg::LimitReset;

    // directed table; empty-frame results are typed in, the rest predicted
    dir_rows = '{
      // hunting from reset over plain noise
      '{ROW_NOISE, 32'd0, 32'd6, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      // empty frame at the reset limit
      '{ROW_FRAME, 32'd5, 32'd0, 32'd9, -1, -1, FILL_RANDOM, 1'b1, empty_res(31'd5, 31'd9)},
      // single payload byte, zero frame and source words
      '{ROW_FRAME, 32'd0, 32'd1, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      // largest frame and source words
      '{ROW_FRAME, 32'h7FFF_FFFF, 32'd3, 32'h7FFF_FFFF, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, -1, -1, FILL_RANDOM, 1'b1,
        empty_res(31'h7FFF_FFFF, 31'h7FFF_FFFF)},
      // negative frame, size and source words are all rejected
      '{ROW_FRAME, 32'h8000_0000, 32'd2, 32'd1, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd1, 32'hFFFF_FFFF, 32'd1, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd1, 32'd2, 32'h8000_0001, -1, -1, FILL_RANDOM, 1'b0, '0},
      // size equal to the limit is rejected, one below is taken
      '{ROW_FRAME, 32'd1, 32'd10000000, 32'd1, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd1, 32'd9999999, 32'd1, HdrLen + 2, -1, FILL_RANDOM, 1'b0, '0},
      // corrupted first marker byte, then corrupted zero terminator
      '{ROW_FRAME, 32'd1, 32'd2, 32'd1, -1, 0, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd1, 32'd2, 32'd1, -1, sml_pkg::MarkerLen - 1, FILL_RANDOM, 1'b0, '0},
      // link reset inside a header, then a clean frame
      '{ROW_FRAME, 32'd2, 32'd3, 32'd2, 20, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd3, 32'd4, 32'd3, -1, -1, FILL_RANDOM, 1'b0, '0},
      // link reset inside a payload
      '{ROW_FRAME, 32'd4, 32'd10, 32'd4, HdrLen + 4, -1, FILL_RANDOM, 1'b0, '0},
      // a header hidden in a payload is passed through, not taken
      '{ROW_FRAME, 32'd5, 32'd45, 32'd5, -1, -1, FILL_NESTED, 1'b0, '0},
      '{ROW_LINK_RESET, 32'd0, 32'd0, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd6, 32'd4, 32'd6, -1, -1, FILL_EXTREME, 1'b0, '0},
      // partial marker, then a real header overlapping the hunt
      '{ROW_PREFIX, 32'd0, 32'd10, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd1, 32'd0, 32'd2, -1, -1, FILL_RANDOM, 1'b1, empty_res(31'd1, 31'd2)},
      // limit of one: only empty frames pass
      '{ROW_LIMIT, 32'd0, 32'd1, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd8, 32'd1, 32'd8, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd3, 32'd0, 32'd4, -1, -1, FILL_RANDOM, 1'b1, empty_res(31'd3, 31'd4)},
      // zero limit rejects every header
      '{ROW_LIMIT, 32'd0, 32'd0, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd9, 32'd0, 32'd9, -1, -1, FILL_RANDOM, 1'b0, '0},
      // largest limit and largest legal size, dropped by a link reset
      '{ROW_LIMIT, 32'd0, 32'h7FFF_FFFF, 32'd0, -1, -1, FILL_RANDOM, 1'b0, '0},
      '{ROW_FRAME, 32'd10, 32'h7FFF_FFFE, 32'd10, HdrLen + 6, -1, FILL_RANDOM, 1'b0, '0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_NOISE: repeat (dir_rows[i].size) put_byte(8'($urandom), 1'b0);
        ROW_PREFIX: for (int k = 0; k < dir_rows[i].size; k++) begin
          put_byte(sml_pkg::SyncMarker[k], 1'b0);
        end
        ROW_LINK_RESET: put_byte(8'hA5, 1'b1);
        ROW_LIMIT: write_limit(dir_rows[i].size[sml_pkg::WordW-1:0]);
        default: send_frame(dir_rows[i].frame, dir_rows[i].size, dir_rows[i].source,
                            dir_rows[i].cut, dir_rows[i].flip, dir_rows[i].fill,
                            dir_rows[i].typed, dir_rows[i].exp);
      endcase
    end

    // random phases, each under its own limit and idle pattern
    write_limit(sml_pkg::LimitReset);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(20);

    write_limit(31'h7FFF_FFFF);
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    run_random(20);

    write_limit(31'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    run_random(20);

    // receiver holds off while the sender keeps offering, so the block backs up
    write_limit(31'($urandom_range(2, 40)));
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    hold_cycles    = 300;
    send_frame(32'd7, 32'd1, 32'd7, -1, -1, FILL_RANDOM, 1'b0, '0);
    run_random(20);

    write_limit(31'd24);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(20);

    wait_drained();
    if (err_count == 0) begin
      $display("tb_sync_marker_length_deframer_top: done, clean");
    end else begin
      $display("tb_sync_marker_length_deframer_top: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb_sync_marker_length_deframer_top: done, errors");
    $finish;
  end

endmodule
